// ===== rtl/anp_pkg.sv =====
package anp_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEFT_W  = 10;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [BYTE_W-1:0] ROOT_CHAR   = 8'h5C;
    localparam logic [BYTE_W-1:0] PARENT_CHAR = 8'h5E;
    localparam logic [BYTE_W-1:0] DUAL_PREFIX = 8'h2E;
    localparam logic [BYTE_W-1:0] MULTI_PREFIX = 8'h2F;
    localparam logic [BYTE_W-1:0] NULL_NAME   = 8'h00;
    localparam logic [LEFT_W-1:0] LEFT_MAX    = 10'd1023;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'b001,
        PH_COUNT = 3'b010,
        PH_SEG   = 3'b100
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] name_byte;
        logic              byte_present;
        logic              name_end;
    } result_t;

    // up to two results handed from the parser to the output queue
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// ===== rtl/anp_byte_if.sv =====
interface anp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

// ===== rtl/anp_name_if.sv =====
interface anp_name_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_byte;
    logic       byte_present;
    logic       name_end;

    modport source (output valid, output name_byte, output byte_present, output name_end,
                    input ready);
    modport sink (input valid, input name_byte, input byte_present, input name_end,
                  output ready);
endinterface

// ===== rtl/anp_parser.sv =====
module anp_parser
    import anp_pkg::*;
#(
    parameter int SEGMENT_LENGTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    anp_byte_if.sink   byte_in,
    input  logic       room,
    output push_t      push
);

    localparam int PROD_W = BYTE_W + 4;

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] held_reg, held_next;
    logic [LEFT_W-1:0] left_reg, left_next;

    logic              accept;
    logic              consume;
    logic [BYTE_W-1:0] b;
    logic [PROD_W-1:0] product;
    logic [LEFT_W-1:0] total;
    logic              have_prefix;
    result_t           prefix_res;
    result_t           empty_res;

    assign accept  = byte_in.valid & byte_in.ready;
    assign consume = in_valid_reg & room;
    assign byte_in.ready = ~in_valid_reg | room;

    assign b       = in_byte_reg;
    assign product = {{(PROD_W-BYTE_W){1'b0}}, b} * PROD_W'(SEGMENT_LENGTH);
    assign total   = (product > PROD_W'(LEFT_MAX)) ? LEFT_MAX : product[LEFT_W-1:0];

    assign have_prefix = (held_reg != NULL_NAME);
    assign prefix_res  = '{name_byte: held_reg, byte_present: 1'b1, name_end: 1'b0};
    assign empty_res   = '{name_byte: held_reg, byte_present: have_prefix, name_end: 1'b1};

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        left_next  = left_reg;
        push       = '0;
        if (consume)
        begin
            case (phase_reg)
                PH_SEG:
                begin
                    push.count = 2'd1;
                    push.first = '{name_byte: b, byte_present: 1'b1,
                                   name_end: (left_reg <= LEFT_W'(1))};
                    if (left_reg <= LEFT_W'(1))
                    begin
                        left_next  = '0;
                        phase_next = PH_LEAD;
                    end
                    else
                    begin
                        left_next = left_reg - LEFT_W'(1);
                    end
                end
                PH_COUNT:
                begin
                    if (total == '0)
                    begin
                        push.count = 2'd1;
                        push.first = empty_res;
                        held_next  = NULL_NAME;
                        left_next  = '0;
                        phase_next = PH_LEAD;
                    end
                    else
                    begin
                        push.count = {1'b0, have_prefix};
                        push.first = prefix_res;
                        held_next  = NULL_NAME;
                        left_next  = total;
                        phase_next = PH_SEG;
                    end
                end
                default:
                begin
                    phase_next = PH_LEAD;
                    if (b == ROOT_CHAR || b == PARENT_CHAR)
                    begin
                        if (!have_prefix)
                        begin
                            held_next = b;
                        end
                    end
                    else if (b == DUAL_PREFIX)
                    begin
                        push.count = {1'b0, have_prefix};
                        push.first = prefix_res;
                        held_next  = NULL_NAME;
                        left_next  = LEFT_W'(2 * SEGMENT_LENGTH);
                        phase_next = PH_SEG;
                    end
                    else if (b == MULTI_PREFIX)
                    begin
                        phase_next = PH_COUNT;
                    end
                    else if (b == NULL_NAME)
                    begin
                        push.count = 2'd1;
                        push.first = empty_res;
                        held_next  = NULL_NAME;
                        left_next  = '0;
                    end
                    else
                    begin
                        held_next = NULL_NAME;
                        if (have_prefix)
                        begin
                            push.count  = 2'd2;
                            push.first  = prefix_res;
                            push.second = '{name_byte: b, byte_present: 1'b1,
                                            name_end: (SEGMENT_LENGTH <= 1)};
                        end
                        else
                        begin
                            push.count = 2'd1;
                            push.first = '{name_byte: b, byte_present: 1'b1,
                                           name_end: (SEGMENT_LENGTH <= 1)};
                        end
                        if (SEGMENT_LENGTH <= 1)
                        begin
                            left_next  = '0;
                            phase_next = PH_LEAD;
                        end
                        else
                        begin
                            left_next  = LEFT_W'(SEGMENT_LENGTH - 1);
                            phase_next = PH_SEG;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_LEAD;
            held_reg     <= NULL_NAME;
            left_reg     <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            phase_reg    <= phase_next;
            held_reg     <= held_next;
            left_reg     <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= byte_in.stream_byte;
        end
    end

endmodule

// ===== rtl/anp_out_queue.sv =====
module anp_out_queue
    import anp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  push_t      push,
    output logic       room,
    anp_name_if.source name_out
);

    result_t         entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0] count_reg, count_next;
    logic            pop;
    result_t         head;

    assign room = (count_reg <= Q_CW'(Q_DEPTH - 2));
    assign head = entry_reg[rd_ptr_reg];
    assign pop  = name_out.valid & name_out.ready;

    assign name_out.valid        = (count_reg != '0);
    assign name_out.name_byte    = head.name_byte;
    assign name_out.byte_present = head.byte_present;
    assign name_out.name_end     = head.name_end;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + Q_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + Q_AW'(pop);
        count_next  = count_reg + Q_CW'(push.count) - Q_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_reg + Q_AW'(1)] <= push.second;
        end
    end

endmodule

// ===== rtl/aml_namestring_parser.sv =====
// Throughput: one byte per cycle; a byte that yields two results (prefix plus first
// character) always follows a prefix byte that yields none, so the input stalls only
// while the output is not ready.
// Reset: rst_n async active low; clears the input stage, parse phase, held
// prefix, remaining name-byte count and the 4-entry output queue.
module aml_namestring_parser
    import anp_pkg::*;
#(
    parameter int SEGMENT_LENGTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    anp_byte_if.sink   byte_in,
    anp_name_if.source name_out
);

    push_t push;
    logic  room;

    anp_parser #(
        .SEGMENT_LENGTH(SEGMENT_LENGTH)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .room    (room),
        .push    (push)
    );

    anp_out_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .name_out (name_out)
    );

`ifndef NO_ASSERTIONS
    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> room)
        else $error("push into full output queue");

    a_push_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd3)
        else $error("illegal push count");

    a_marker_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (name_out.valid && !name_out.byte_present) |-> name_out.name_end)
        else $error("end-only marker without name_end");

    a_pair_after_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (push.first.byte_present && !push.first.name_end))
        else $error("two results without leading prefix");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import anp_pkg::*;

    localparam int SEG_LEN     = 4;
    localparam int RANDOM_BYTES = 500;

    logic clk;
    logic rst_n;

    anp_byte_if byte_if ();
    anp_name_if name_if ();

    aml_namestring_parser #(
        .SEGMENT_LENGTH(SEG_LEN)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (byte_if),
        .name_out (name_if)
    );

    class name_scoreboard;
        result_t     expected_chars[$];
        phase_t      parse_phase;
        logic [7:0]  held_prefix;
        logic [9:0]  bytes_left;
        int          errors;

        function new();
            parse_phase = PH_LEAD;
            held_prefix = '0;
            bytes_left  = '0;
            errors      = 0;
        endfunction

        function void push_char(logic [7:0] b, logic present, logic last);
            result_t r;
            r.name_byte    = b;
            r.byte_present = present;
            r.name_end     = last;
            expected_chars.push_back(r);
        endfunction

        function void emit_prefix();
            if (held_prefix != '0)
            begin
                push_char(held_prefix, 1'b1, 1'b0);
                held_prefix = '0;
            end
        endfunction

        // empty name: held prefix closes it, or an end-only marker
        function void finish_empty();
            if (held_prefix != '0)
                push_char(held_prefix, 1'b1, 1'b1);
            else
                push_char(8'h00, 1'b0, 1'b1);
            held_prefix = '0;
            bytes_left  = '0;
            parse_phase = PH_LEAD;
        endfunction

        function void note_byte(logic [7:0] b);
            int total;
            logic last;
            case (parse_phase)
                PH_SEG:
                begin
                    last = (bytes_left <= 10'd1);
                    push_char(b, 1'b1, last);
                    if (last)
                    begin
                        bytes_left  = '0;
                        parse_phase = PH_LEAD;
                    end
                    else
                        bytes_left = bytes_left - 10'd1;
                end
                PH_COUNT:
                begin
                    total = int'(b) * SEG_LEN;
                    if (total > int'(LEFT_MAX))
                        total = int'(LEFT_MAX);
                    if (total == 0)
                        finish_empty();
                    else
                    begin
                        emit_prefix();
                        bytes_left  = total[9:0];
                        parse_phase = PH_SEG;
                    end
                end
                default:
                begin
                    if (b == ROOT_CHAR || b == PARENT_CHAR)
                    begin
                        if (held_prefix == '0)
                            held_prefix = b;
                        parse_phase = PH_LEAD;
                    end
                    else if (b == DUAL_PREFIX)
                    begin
                        emit_prefix();
                        bytes_left  = 10'(2 * SEG_LEN);
                        parse_phase = PH_SEG;
                    end
                    else if (b == MULTI_PREFIX)
                        parse_phase = PH_COUNT;
                    else if (b == NULL_NAME)
                        finish_empty();
                    else
                    begin
                        emit_prefix();
                        if (SEG_LEN <= 1)
                        begin
                            push_char(b, 1'b1, 1'b1);
                            bytes_left  = '0;
                            parse_phase = PH_LEAD;
                        end
                        else
                        begin
                            push_char(b, 1'b1, 1'b0);
                            bytes_left  = 10'(SEG_LEN - 1);
                            parse_phase = PH_SEG;
                        end
                    end
                end
            endcase
        endfunction

        function void report(string field, int exp_val, int act_val);
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, exp_val, act_val);
        endfunction

        function void check_char(result_t got);
            result_t exp_r;
            if (expected_chars.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0h/%0b/%0b",
                         $time, got.name_byte, got.byte_present, got.name_end);
                return;
            end
            exp_r = expected_chars.pop_front();
            if (got.name_byte != exp_r.name_byte)
                report("name_byte", exp_r.name_byte, got.name_byte);
            if (got.byte_present != exp_r.byte_present)
                report("byte_present", exp_r.byte_present, got.byte_present);
            if (got.name_end != exp_r.name_end)
                report("name_end", exp_r.name_end, got.name_end);
        endfunction
    endclass

    name_scoreboard sb;
    bit             random_phase;
    bit             hold_off;
    bit             calm;
    int             bytes_sent;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < 18)
        begin
            byte_if.valid = 1'b0;
            @(negedge clk);
        end
        byte_if.valid       = 1'b1;
        byte_if.stream_byte = b;
        do
            @(posedge clk);
        while (!byte_if.ready);
        sb.note_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_segments(input int count);
        repeat (count * SEG_LEN) send_byte(8'($urandom_range(255)));
    endtask

    task automatic send_random_name();
        int         n_pre;
        int         form;
        logic [7:0] lead;
        logic [7:0] count;
        n_pre = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 3);
        repeat (n_pre) send_byte($urandom_range(1) ? ROOT_CHAR : PARENT_CHAR);
        form = $urandom_range(99);
        if (form < 10)
            send_byte(8'($urandom_range(255)));
        else if (form < 20)
            send_byte(NULL_NAME);
        else if (form < 45)
        begin
            send_byte(DUAL_PREFIX);
            send_segments(2);
        end
        else if (form < 65)
        begin
            count = ($urandom_range(9) == 0) ? 8'($urandom_range(5, 12))
                                             : 8'($urandom_range(0, 4));
            send_byte(MULTI_PREFIX);
            send_byte(count);
            send_segments(int'(count));
        end
        else
        begin
            do
                lead = 8'($urandom_range(255));
            while (lead == ROOT_CHAR || lead == PARENT_CHAR || lead == DUAL_PREFIX ||
                   lead == MULTI_PREFIX || lead == NULL_NAME);
            send_byte(lead);
            repeat (SEG_LEN - 1) send_byte(8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        logic [7:0] directed_seq[] = '{
            NULL_NAME,
            ROOT_CHAR, NULL_NAME,
            PARENT_CHAR, PARENT_CHAR, ROOT_CHAR, 8'hFF, 8'h01, 8'h80, 8'h7F,
            DUAL_PREFIX, 8'h00, 8'hFF, ROOT_CHAR, PARENT_CHAR,
            DUAL_PREFIX, MULTI_PREFIX, 8'h55, 8'hAA,
            PARENT_CHAR, MULTI_PREFIX, 8'h00,
            MULTI_PREFIX, 8'h00,
            ROOT_CHAR, MULTI_PREFIX, 8'h01, 8'h41, NULL_NAME, 8'h5F, 8'h31
        };
        int target;
        byte_if.valid       = 1'b0;
        byte_if.stream_byte = 8'h00;
        rst_n               = 1'b0;
        random_phase        = 1'b0;
        bytes_sent          = 0;
        sb = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_seq[i])
            send_byte(directed_seq[i]);

        random_phase = 1'b1;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target)
            send_random_name();

        // count that sets the top bit of the byte counter
        send_byte(ROOT_CHAR);
        send_byte(MULTI_PREFIX);
        send_byte(8'h80);
        send_segments(128);
        repeat (5) send_random_name();

        byte_if.valid = 1'b0;
        while (sb.expected_chars.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (sb.errors == 0 && sb.expected_chars.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        result_t got;
        name_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            name_if.ready = !hold_off && (calm || $urandom_range(99) >= 18);
            @(posedge clk);
            if (name_if.valid && name_if.ready)
            begin
                got.name_byte    = name_if.name_byte;
                got.byte_present = name_if.byte_present;
                got.name_end     = name_if.name_end;
                sb.check_char(got);
            end
        end
    end

    // long output stall, then a stretch with no idling on either side
    initial
    begin
        hold_off = 1'b0;
        calm     = 1'b0;
        wait (random_phase);
        repeat (200) @(posedge clk);
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
        repeat (300) @(posedge clk);
        calm = 1'b1;
        repeat (500) @(posedge clk);
        calm = 1'b0;
    end

endmodule
